// File: hw/rtl/rsbm_pkg.sv
// Shared types and constants for the receive slot batch manager.
package rsbm_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int SLOT_W = 6;
   localparam int CNT_W = 7;
   localparam int LEN_W = 16;
   localparam int TIME_W = 63;
   localparam int OFF_W = 22;

   localparam logic REG_SLOTS = 1'b0;
   localparam logic REG_BYTES = 1'b1;

   typedef enum logic [2:0] {
      OP_ACQUIRE    = 3'd0,
      OP_REL_RECV   = 3'd1,
      OP_COMMIT     = 3'd2,
      OP_SEAL       = 3'd3,
      OP_REL_BATCH  = 3'd4,
      OP_RESET      = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_BLOCK = 2'd1,
      STS_BAD   = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_NORM,
      ST_SCAN,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_SEAL_RD,
      ST_SEAL_OUT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0] slots;
      logic [LEN_W-1:0] bytes;
   } cfg_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              chan;
      logic [LEN_W-1:0]  len;
      logic [TIME_W-1:0] tm;
   } desc_type;

endpackage

// File: hw/rtl/rsbm_desc_ram.sv
// Descriptor store: one write port, one registered read port.
module rsbm_desc_ram (
   input  logic                           clock,
   input  logic                           we,
   input  logic [rsbm_pkg::SLOT_W-1:0]    waddr,
   input  rsbm_pkg::desc_type             wdata,
   input  logic [rsbm_pkg::SLOT_W-1:0]    raddr,
   output rsbm_pkg::desc_type             rdata
);

   rsbm_pkg::desc_type mem [rsbm_pkg::MAX_SLOTS];
   rsbm_pkg::desc_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/rsbm_ctrl.sv
// Sequencer, slot bitmaps and result register for the slot batch manager.
module rsbm_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  rsbm_pkg::cfg_type                cfg,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_op,
   input  logic [rsbm_pkg::SLOT_W-1:0]      req_slot,
   input  logic                             req_chan,
   input  logic [rsbm_pkg::LEN_W-1:0]       req_len,
   input  logic [rsbm_pkg::TIME_W-1:0]      req_time,
   input  logic [rsbm_pkg::CNT_W-1:0]       req_cnt,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [rsbm_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [rsbm_pkg::OFF_W-1:0]       rsp_off,
   output logic                             rsp_chan,
   output logic [rsbm_pkg::LEN_W-1:0]       rsp_len,
   output logic [rsbm_pkg::TIME_W-1:0]      rsp_time,
   output logic [rsbm_pkg::CNT_W-1:0]       rsp_total,
   output logic                             rsp_last
);

   localparam int SW = rsbm_pkg::SLOT_W;
   localparam int CW = rsbm_pkg::CNT_W;
   localparam int NS = rsbm_pkg::MAX_SLOTS;

   rsbm_pkg::state_type state_ff, state_in;
   logic [2:0]  op_ff;
   logic [SW-1:0] slot_ff;
   logic        chan_ff;
   logic [rsbm_pkg::LEN_W-1:0] len_ff;
   logic [rsbm_pkg::TIME_W-1:0] tm_ff;
   logic [CW-1:0] cnt_ff;

   logic [NS-1:0] recv_ff, recv_in, batch_ff, batch_in;
   logic [SW-1:0] ss_ff, ss_in, ptr_ff, ptr_in, res_slot_ff, res_slot_in;
   logic [CW-1:0] cc_ff, cc_in, step_ff, step_in;
   logic        lease_ff, lease_in;
   logic [rsbm_pkg::TIME_W-1:0] latest_ff, latest_in;
   rsbm_pkg::status_type res_sts_ff, res_sts_in;

   logic        ov_ff, ov_in;
   logic [1:0]  o_sts_ff, o_sts_in;
   logic [SW-1:0] o_slot_ff, o_slot_in;
   logic [rsbm_pkg::OFF_W-1:0] o_off_ff, o_off_in;
   logic        o_chan_ff, o_chan_in;
   logic [rsbm_pkg::LEN_W-1:0] o_len_ff, o_len_in;
   logic [rsbm_pkg::TIME_W-1:0] o_tm_ff, o_tm_in;
   logic [CW-1:0] o_total_ff, o_total_in;
   logic        o_last_ff, o_last_in;

   logic        out_free, accept;
   logic        ram_we;
   rsbm_pkg::desc_type ram_wdata, ram_rdata;
   logic [SW-1:0] ptr_next;
   logic        ptr_free, commit_ok, seal_ok, last_seal;
   logic [rsbm_pkg::OFF_W-1:0] mul_off;
   logic [SW-1:0] mul_slot;

   assign out_free  = !ov_ff || rsp_ready;
   assign req_ready = (state_ff == rsbm_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign ptr_next  = ({1'b0, ptr_ff} + CW'(1) == cfg.slots) ? '0 : ptr_ff + SW'(1);
   assign ptr_free  = !recv_ff[ptr_ff] && !batch_ff[ptr_ff];
   assign commit_ok = !lease_ff && ({1'b0, slot_ff} < cfg.slots) && (cc_ff < cfg.slots)
                      && recv_ff[slot_ff] && (len_ff != '0) && (len_ff <= cfg.bytes)
                      && (tm_ff != '0) && (tm_ff >= latest_ff);
   assign seal_ok   = !lease_ff && (cnt_ff != '0) && (cnt_ff == cc_ff);
   assign last_seal = ({1'b0, ptr_ff} + CW'(1) == cc_ff);

   // Shared offset multiplier: seal entries take the stored slot, others the result slot.
   assign mul_slot = (state_ff == rsbm_pkg::ST_SEAL_OUT) ? ram_rdata.slot : res_slot_ff;
   assign mul_off  = rsbm_pkg::OFF_W'(rsbm_pkg::OFF_W'(mul_slot) * rsbm_pkg::OFF_W'(cfg.bytes));

   assign ram_we    = (state_ff == rsbm_pkg::ST_EXEC) && (op_ff == rsbm_pkg::OP_COMMIT)
                      && commit_ok;
   assign ram_wdata = '{slot: slot_ff, chan: chan_ff, len: len_ff, tm: tm_ff};

   rsbm_desc_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (cc_ff[SW-1:0]),
      .wdata (ram_wdata),
      .raddr (ptr_ff),
      .rdata (ram_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rsbm_pkg::ST_IDLE: begin
            if (accept) state_in = rsbm_pkg::ST_EXEC;
         end
         rsbm_pkg::ST_EXEC: begin
            unique case (op_ff)
               rsbm_pkg::OP_ACQUIRE: state_in = rsbm_pkg::ST_NORM;
               rsbm_pkg::OP_SEAL:
                  state_in = seal_ok ? rsbm_pkg::ST_SEAL_RD : rsbm_pkg::ST_DONE;
               rsbm_pkg::OP_REL_BATCH:
                  state_in = (lease_ff && cc_ff != '0) ? rsbm_pkg::ST_FREE_RD
                                                       : rsbm_pkg::ST_DONE;
               rsbm_pkg::OP_RESET:
                  state_in = (!lease_ff && cc_ff != '0) ? rsbm_pkg::ST_FREE_RD
                                                        : rsbm_pkg::ST_DONE;
               default: state_in = rsbm_pkg::ST_DONE;
            endcase
         end
         rsbm_pkg::ST_NORM: begin
            if ({1'b0, ptr_ff} < cfg.slots) state_in = rsbm_pkg::ST_SCAN;
         end
         rsbm_pkg::ST_SCAN: begin
            if (ptr_free || step_ff + CW'(1) == cfg.slots) state_in = rsbm_pkg::ST_DONE;
         end
         rsbm_pkg::ST_FREE_RD: state_in = rsbm_pkg::ST_FREE_CHK;
         rsbm_pkg::ST_FREE_CHK: begin
            state_in = last_seal ? rsbm_pkg::ST_DONE : rsbm_pkg::ST_FREE_RD;
         end
         rsbm_pkg::ST_SEAL_RD: state_in = rsbm_pkg::ST_SEAL_OUT;
         rsbm_pkg::ST_SEAL_OUT: begin
            if (out_free) state_in = last_seal ? rsbm_pkg::ST_IDLE : rsbm_pkg::ST_SEAL_RD;
         end
         rsbm_pkg::ST_DONE: begin
            if (out_free) state_in = rsbm_pkg::ST_IDLE;
         end
         default: state_in = rsbm_pkg::ST_IDLE;
      endcase
   end

   // Datapath updates.
   always_comb begin
      recv_in     = recv_ff;
      batch_in    = batch_ff;
      ss_in       = ss_ff;
      ptr_in      = ptr_ff;
      step_in     = step_ff;
      cc_in       = cc_ff;
      lease_in    = lease_ff;
      latest_in   = latest_ff;
      res_sts_in  = res_sts_ff;
      res_slot_in = res_slot_ff;
      ov_in       = ov_ff && !rsp_ready;
      o_sts_in    = o_sts_ff;
      o_slot_in   = o_slot_ff;
      o_off_in    = o_off_ff;
      o_chan_in   = o_chan_ff;
      o_len_in    = o_len_ff;
      o_tm_in     = o_tm_ff;
      o_total_in  = o_total_ff;
      o_last_in   = o_last_ff;
      case (state_ff)
         rsbm_pkg::ST_EXEC: begin
            res_sts_in  = rsbm_pkg::STS_OK;
            res_slot_in = '0;
            ptr_in      = '0;
            step_in     = '0;
            case (op_ff)
               rsbm_pkg::OP_ACQUIRE: ptr_in = ss_ff;
               rsbm_pkg::OP_REL_RECV: begin
                  if ({1'b0, slot_ff} < cfg.slots && recv_ff[slot_ff]) begin
                     recv_in[slot_ff] = 1'b0;
                     if (slot_ff < ss_ff) ss_in = slot_ff;
                  end else begin
                     res_sts_in = rsbm_pkg::STS_BAD;
                  end
               end
               rsbm_pkg::OP_COMMIT: begin
                  if (commit_ok) begin
                     recv_in[slot_ff]  = 1'b0;
                     batch_in[slot_ff] = 1'b1;
                     latest_in = tm_ff;
                     cc_in     = cc_ff + CW'(1);
                  end else begin
                     res_sts_in = rsbm_pkg::STS_BAD;
                  end
               end
               rsbm_pkg::OP_SEAL: begin
                  if (seal_ok) lease_in = 1'b1;
                  else res_sts_in = rsbm_pkg::STS_BAD;
               end
               rsbm_pkg::OP_REL_BATCH: begin
                  lease_in = 1'b0;
               end
               rsbm_pkg::OP_RESET: begin
                  if (lease_ff) res_sts_in = rsbm_pkg::STS_BAD;
               end
               default: res_sts_in = rsbm_pkg::STS_BAD;
            endcase
         end
         rsbm_pkg::ST_NORM: begin
            // Fold a stale search start into the current slot count.
            if ({1'b0, ptr_ff} >= cfg.slots) ptr_in = SW'({1'b0, ptr_ff} - cfg.slots);
         end
         rsbm_pkg::ST_SCAN: begin
            if (ptr_free) begin
               recv_in[ptr_ff] = 1'b1;
               ss_in       = ptr_next;
               res_slot_in = ptr_ff;
            end else if (step_ff + CW'(1) == cfg.slots) begin
               res_sts_in = rsbm_pkg::STS_BLOCK;
            end else begin
               step_in = step_ff + CW'(1);
               ptr_in  = ptr_next;
            end
         end
         rsbm_pkg::ST_FREE_CHK: begin
            if (batch_ff[ram_rdata.slot]) begin
               batch_in[ram_rdata.slot] = 1'b0;
               if (ram_rdata.slot < ss_ff) ss_in = ram_rdata.slot;
            end
            ptr_in = ptr_ff + SW'(1);
            if (last_seal) cc_in = '0;
         end
         rsbm_pkg::ST_SEAL_OUT: begin
            if (out_free) begin
               ov_in      = 1'b1;
               o_sts_in   = rsbm_pkg::STS_OK;
               o_slot_in  = ram_rdata.slot;
               o_off_in   = mul_off;
               o_chan_in  = ram_rdata.chan;
               o_len_in   = ram_rdata.len;
               o_tm_in    = ram_rdata.tm;
               o_total_in = cc_ff;
               o_last_in  = last_seal;
               ptr_in     = ptr_ff + SW'(1);
            end
         end
         rsbm_pkg::ST_DONE: begin
            if (out_free) begin
               ov_in      = 1'b1;
               o_sts_in   = res_sts_ff;
               o_slot_in  = res_slot_ff;
               o_off_in   = mul_off;
               o_chan_in  = 1'b0;
               o_len_in   = '0;
               o_tm_in    = '0;
               o_total_in = cc_ff;
               o_last_in  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rsbm_pkg::ST_IDLE;
         recv_ff   <= '0;
         batch_ff  <= '0;
         ss_ff     <= '0;
         cc_ff     <= '0;
         lease_ff  <= 1'b0;
         latest_ff <= '0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         recv_ff   <= recv_in;
         batch_ff  <= batch_in;
         ss_ff     <= ss_in;
         cc_ff     <= cc_in;
         lease_ff  <= lease_in;
         latest_ff <= latest_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         slot_ff <= req_slot;
         chan_ff <= req_chan;
         len_ff  <= req_len;
         tm_ff   <= req_time;
         cnt_ff  <= req_cnt;
      end
      ptr_ff      <= ptr_in;
      step_ff     <= step_in;
      res_sts_ff  <= res_sts_in;
      res_slot_ff <= res_slot_in;
      o_sts_ff    <= o_sts_in;
      o_slot_ff   <= o_slot_in;
      o_off_ff    <= o_off_in;
      o_chan_ff   <= o_chan_in;
      o_len_ff    <= o_len_in;
      o_tm_ff     <= o_tm_in;
      o_total_ff  <= o_total_in;
      o_last_ff   <= o_last_in;
   end

   assign rsp_valid  = ov_ff;
   assign rsp_status = o_sts_ff;
   assign rsp_slot   = o_slot_ff;
   assign rsp_off    = o_off_ff;
   assign rsp_chan   = o_chan_ff;
   assign rsp_len    = o_len_ff;
   assign rsp_time   = o_tm_ff;
   assign rsp_total  = o_total_ff;
   assign rsp_last   = o_last_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == rsbm_pkg::ST_EXEC)
      else $error("sequencer did not start after accept");
   a_owner_exclusive: assert property (@(posedge clock) disable iff (reset)
      (recv_ff & batch_ff) == '0)
      else $error("slot both receive-owned and batch-owned");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cc_ff <= CW'(NS))
      else $error("descriptor count overflow");
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      ov_ff && o_sts_ff != rsbm_pkg::STS_OK |-> o_last_ff)
      else $error("error result not marked last");

endmodule

// File: hw/rtl/rx_slot_batch_manager.sv
// Top level: stream ports, configuration registers and sequencer.
//
//   channel  dir  payload
//   req_*    in   tuser: operation, channel_kind; tdata: slot, length, time, seal count
//   rsp_*    out  tuser: status, entry_channel; tdata: slot, offset, length, time, total
//   csr_*    in   register write, index 0 slots_in_use, 1 slot_bytes
//
// Simple operations pass through the execute and done states; acquire first folds the
// search start into the slot count, then probes slots one by one for a free one;
// batch release reads and then frees each descriptor, and seal reads and then sends each result.
// Synchronous active-high reset frees all slots and clears the lease.
// Input is not taken while an item is in work; a waiting result holds only the next result.
module rx_slot_batch_manager (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // slot_number, datagram_length, arrival_time, seal_count
   input  logic [3:0]   req_tuser,   // operation, channel_kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // granted_slot, byte_offset, entry_length,
                                     // entry_time, committed_total
   output logic [2:0]   rsp_tuser,   // status, entry_channel
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [15:0]  csr_wdata
);

   logic [rsbm_pkg::CNT_W-1:0] slots_ff;
   logic [rsbm_pkg::LEN_W-1:0] bytes_ff;
   rsbm_pkg::cfg_type cfg;
   logic [1:0]  sts;
   logic [5:0]  slot;
   logic [21:0] off;
   logic        chan;
   logic [15:0] len;
   logic [62:0] tm;
   logic [6:0]  total;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= 7'd64;
         bytes_ff <= 16'd1500;
      end else if (csr_we) begin
         unique case (csr_addr)
            rsbm_pkg::REG_SLOTS: begin
               // Clamp the slot count into its legal range.
               if (csr_wdata[6:0] == '0) slots_ff <= 7'd1;
               else if (csr_wdata[6:0] > 7'(rsbm_pkg::MAX_SLOTS))
                  slots_ff <= 7'(rsbm_pkg::MAX_SLOTS);
               else slots_ff <= csr_wdata[6:0];
            end
            rsbm_pkg::REG_BYTES: bytes_ff <= (csr_wdata == '0) ? 16'd1 : csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = '{slots: slots_ff, bytes: bytes_ff};

   rsbm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser[2:0]),
      .req_slot   (req_tdata[5:0]),
      .req_chan   (req_tuser[3]),
      .req_len    (req_tdata[21:6]),
      .req_time   (req_tdata[84:22]),
      .req_cnt    (req_tdata[91:85]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (sts),
      .rsp_slot   (slot),
      .rsp_off    (off),
      .rsp_chan   (chan),
      .rsp_len    (len),
      .rsp_time   (tm),
      .rsp_total  (total),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, total, tm, len, off, slot};
   assign rsp_tuser = {chan, sts};

endmodule
